// ----- rtl/cursor_sequence_buffer_assert.svh -----
// Assertion macros used by the cursor sequence buffer top level.
`ifndef CURSOR_SEQUENCE_BUFFER_ASSERT_SVH
`define CURSOR_SEQUENCE_BUFFER_ASSERT_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define CSB_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("csb assertion failed");

// Next-cycle implication, checked on every clock edge outside reset.
`define CSB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("csb assertion failed");

`endif

// ----- rtl/csb_pkg.sv -----
// Package with the types and constants of the cursor sequence buffer.
package csb_pkg;

  localparam int CAPACITY = 32;
  localparam int DATA_W   = 32;
  localparam int IDX_W    = 5;
  localparam int CNT_W    = 6;

  typedef enum logic [2:0] {
    CMD_START   = 3'd0,
    CMD_ADVANCE = 3'd1,
    CMD_INSERT  = 3'd2,
    CMD_ATTACH  = 3'd3,
    CMD_REMOVE  = 3'd4,
    CMD_QUERY   = 3'd5
  } csb_cmd_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_NOCUR = 2'd2
  } csb_status_t;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [31:0] entry;
  } csb_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [5:0]  count;
    logic        has_current;
    logic [4:0]  cursor_pos;
    logic [31:0] current_value;
  } csb_out_t;

  // Broadcast from the controller to every cell of the storage chain.
  typedef struct packed {
    logic              ins;
    logic              rem;
    logic [IDX_W-1:0]  pos;
    logic [DATA_W-1:0] word;
  } csb_shift_t;

  // Controller state as seen after a command.
  typedef struct packed {
    csb_status_t      status;
    logic [CNT_W-1:0] count;
    logic             has_cur;
    logic [IDX_W-1:0] cur_pos;
  } csb_view_t;

endpackage

// ----- rtl/cursor_sequence_buffer.sv -----
// Top level of the cursor sequence buffer: controller, cell chain and result register.
//
//   Channel | Ports                        | Moves
//   input   | in_valid, in_ready, in_data  | one command transaction (cmd, entry)
//   output  | out_valid, out_ready, out_data | one result transaction per command
//
// Every command completes on the edge that accepts it: the cell chain shifts all words in
// parallel, each cell looking only at its two neighbors, and the result is
// captured in the output register on the same edge that accepts the command.
// A new command is taken whenever the output register is empty or being
// drained, so the sustained rate is one transaction per cycle while the output is not stalled.
// Reset (rst_n low, synchronous) empties the buffer and drops the cursor;
// the stored words are not cleared, since only words below the count are read.
// A stalled output holds its result and blocks new commands until taken.
module cursor_sequence_buffer (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  csb_pkg::csb_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output csb_pkg::csb_out_t out_data
);

`include "cursor_sequence_buffer_assert.svh"

  logic                        in_fire;
  logic                        out_valid_r;
  csb_pkg::csb_out_t           out_data_r;
  csb_pkg::csb_shift_t         shift_ctl;
  csb_pkg::csb_view_t          view_nxt;
  csb_pkg::csb_view_t          view_q;
  logic [csb_pkg::DATA_W-1:0]  cell_q   [csb_pkg::CAPACITY];
  logic [csb_pkg::DATA_W-1:0]  cell_nxt [csb_pkg::CAPACITY];
  logic [csb_pkg::DATA_W-1:0]  cur_value;

  // The output register frees itself as soon as its transaction is taken.
  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  csb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (in_fire),
    .cmd_in    (in_data),
    .shift_ctl (shift_ctl),
    .view_nxt  (view_nxt),
    .view_q    (view_q)
  );

  // The chain of cells. The ends see a zero word where no neighbor exists;
  // that value only ever lands beyond the fill count.
  for (genvar g = 0; g < csb_pkg::CAPACITY; g++) begin : g_cell
    logic [csb_pkg::DATA_W-1:0] left_q;
    logic [csb_pkg::DATA_W-1:0] right_q;

    if (g == 0) begin : g_first
      assign left_q = '0;
    end else begin : g_left
      assign left_q = cell_q[g-1];
    end

    if (g == csb_pkg::CAPACITY - 1) begin : g_last
      assign right_q = '0;
    end else begin : g_right
      assign right_q = cell_q[g+1];
    end

    csb_cell u_cell (
      .clk      (clk),
      .idx      (csb_pkg::IDX_W'(g)),
      .ctl      (shift_ctl),
      .left_q   (left_q),
      .right_q  (right_q),
      .data_r   (cell_q[g]),
      .data_nxt (cell_nxt[g])
    );
  end

  // The value under the cursor is taken from the words the chain is about to hold.
  assign cur_value = view_nxt.has_cur ? cell_nxt[view_nxt.cur_pos] : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data_r.status        <= view_nxt.status;
      out_data_r.count         <= view_nxt.count;
      out_data_r.has_current   <= view_nxt.has_cur;
      out_data_r.cursor_pos    <= view_nxt.cur_pos;
      out_data_r.current_value <= cur_value;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A valid cursor always points inside the stored entries.
  `CSB_ASSERT_NOW(a_cursor_in_range, view_q.has_cur, {1'b0, view_q.cur_pos} < view_q.count)
  // Without a current entry the cursor rests at zero.
  `CSB_ASSERT_NOW(a_cursor_parked, !view_q.has_cur, view_q.cur_pos == '0)
  // The buffer never holds more than its capacity.
  `CSB_ASSERT_NOW(a_count_bound, 1'b1, view_q.count <= csb_pkg::CNT_W'(csb_pkg::CAPACITY))
  // An accepted command always leaves a result in the output register.
  `CSB_ASSERT_NEXT(a_result_follows, in_fire, out_valid_r && (out_data_r.count == view_q.count))

endmodule

// ----- rtl/csb_cell.sv -----
// One storage cell of the chain: holds a word, loads a new one or takes a neighbor's.
module csb_cell (
  input  logic                               clk,
  input  logic [csb_pkg::IDX_W-1:0]          idx,
  input  csb_pkg::csb_shift_t                ctl,
  input  logic [csb_pkg::DATA_W-1:0]         left_q,
  input  logic [csb_pkg::DATA_W-1:0]         right_q,
  output logic [csb_pkg::DATA_W-1:0]         data_r,
  output logic [csb_pkg::DATA_W-1:0]         data_nxt
);

  always_comb begin
    data_nxt = data_r;
    if (ctl.ins) begin
      if (idx == ctl.pos) begin
        data_nxt = ctl.word;
      end else if (idx > ctl.pos) begin
        data_nxt = left_q;
      end
    end else if (ctl.rem && (idx >= ctl.pos)) begin
      data_nxt = right_q;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

endmodule

// ----- rtl/csb_ctrl.sv -----
// Command decoder holding the fill count and the cursor of the buffer.
module csb_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        fire,
  input  csb_pkg::csb_in_t            cmd_in,
  output csb_pkg::csb_shift_t         shift_ctl,
  output csb_pkg::csb_view_t          view_nxt,
  output csb_pkg::csb_view_t          view_q
);

  logic [csb_pkg::CNT_W-1:0] fill_r, fill_nxt;
  logic [csb_pkg::IDX_W-1:0] cur_r, cur_nxt;
  logic                      cv_r, cv_nxt;
  csb_pkg::csb_status_t      status;
  logic                      full;
  logic [csb_pkg::CNT_W-1:0] cur_inc;
  logic [csb_pkg::CNT_W-1:0] fill_dec;

  assign full     = (fill_r == csb_pkg::CNT_W'(csb_pkg::CAPACITY));
  assign cur_inc  = {1'b0, cur_r} + csb_pkg::CNT_W'(1);
  assign fill_dec = fill_r - csb_pkg::CNT_W'(1);

  always_comb begin
    fill_nxt       = fill_r;
    cur_nxt        = cur_r;
    cv_nxt         = cv_r;
    status         = csb_pkg::ST_DONE;
    shift_ctl.ins  = 1'b0;
    shift_ctl.rem  = 1'b0;
    shift_ctl.pos  = cur_r;
    shift_ctl.word = cmd_in.entry;
    unique case (cmd_in.cmd)
      csb_pkg::CMD_START: begin
        cur_nxt = '0;
        cv_nxt  = (fill_r != '0);
      end
      csb_pkg::CMD_ADVANCE: begin
        if (!cv_r) begin
          status = csb_pkg::ST_NOCUR;
        end else if (cur_inc >= fill_r) begin
          cur_nxt = '0;
          cv_nxt  = 1'b0;
        end else begin
          cur_nxt = cur_inc[csb_pkg::IDX_W-1:0];
        end
      end
      csb_pkg::CMD_INSERT, csb_pkg::CMD_ATTACH: begin
        if (full) begin
          status = csb_pkg::ST_FULL;
        end else begin
          if (cmd_in.cmd == csb_pkg::CMD_INSERT) begin
            shift_ctl.pos = cv_r ? cur_r : '0;
          end else begin
            shift_ctl.pos = cv_r ? cur_inc[csb_pkg::IDX_W-1:0]
                                 : fill_r[csb_pkg::IDX_W-1:0];
          end
          shift_ctl.ins = fire;
          fill_nxt      = fill_r + csb_pkg::CNT_W'(1);
          cur_nxt       = shift_ctl.pos;
          cv_nxt        = 1'b1;
        end
      end
      csb_pkg::CMD_REMOVE: begin
        if (!cv_r) begin
          status = csb_pkg::ST_NOCUR;
        end else begin
          shift_ctl.rem = fire;
          fill_nxt      = fill_dec;
          if ({1'b0, cur_r} >= fill_dec) begin
            cur_nxt = '0;
            cv_nxt  = 1'b0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      cur_r  <= '0;
      cv_r   <= 1'b0;
    end else if (fire) begin
      fill_r <= fill_nxt;
      cur_r  <= cur_nxt;
      cv_r   <= cv_nxt;
    end
  end

  assign view_nxt.status  = status;
  assign view_nxt.count   = fill_nxt;
  assign view_nxt.has_cur = cv_nxt;
  assign view_nxt.cur_pos = cv_nxt ? cur_nxt : '0;

  assign view_q.status  = csb_pkg::ST_DONE;
  assign view_q.count   = fill_r;
  assign view_q.has_cur = cv_r;
  assign view_q.cur_pos = cur_r;

endmodule

// ----- verif/cursor_sequence_buffer_tb.sv -----
// Self-checking testbench for the cursor sequence buffer, driven by a cycle-free predictor.
module cursor_sequence_buffer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Command codes six and seven are not part of the command set; the block
  // must treat them like a query.
  localparam logic [2:0] CMD_SPARE_A = 3'd6;
  localparam logic [2:0] CMD_SPARE_B = 3'd7;

  localparam int MAX_WAIT     = 6;
  localparam int REPORT_LIMIT = 10;
  localparam int TAIL_CYCLES  = 10;
  localparam int RANDOM_ITEMS = 660;
  localparam int PHASE_LEN    = 40;

  // Workload mixes for the random part. Growing fills the buffer up to the
  // refusal case, shrinking empties it again, balanced wanders in between.
  typedef enum int {
    MIX_GROW,
    MIX_SHRINK,
    MIX_BALANCED
  } mix_t;

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              in_valid  = 1'b0;
  logic              in_ready;
  csb_pkg::csb_in_t  in_data   = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  csb_pkg::csb_out_t out_data;

  // Predicted contents of the buffer and the cursor, updated once for every
  // command transaction that the block accepts.
  logic [csb_pkg::DATA_W-1:0] word_store [csb_pkg::CAPACITY];
  int                         fill_level  = 0;
  int                         cursor_idx  = 0;
  bit                         cursor_live = 1'b0;

  // Results still owed by the block, oldest first.
  csb_pkg::csb_out_t predicted_results [$];

  int mismatch_count = 0;
  int ready_hold     = 0;

  // When set, neither side inserts idle cycles, so the block runs at full rate.
  bit steady_flow = 1'b0;

  cursor_sequence_buffer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Apply one accepted command to the predicted state and return the result
  // that the block has to report for it.
  function automatic csb_pkg::csb_out_t apply_command(csb_pkg::csb_in_t item);
    csb_pkg::csb_out_t    res;
    csb_pkg::csb_status_t outcome;
    int                   slot;
    int                   i;
    outcome = csb_pkg::ST_DONE;
    slot    = 0;
    case (item.cmd)
      csb_pkg::CMD_START: begin
        cursor_idx  = 0;
        cursor_live = (fill_level != 0);
      end
      csb_pkg::CMD_ADVANCE: begin
        if (!cursor_live) begin
          outcome = csb_pkg::ST_NOCUR;
        end else if (cursor_idx + 1 >= fill_level) begin
          // Stepping past the last entry drops the cursor.
          cursor_idx  = 0;
          cursor_live = 1'b0;
        end else begin
          cursor_idx++;
        end
      end
      csb_pkg::CMD_INSERT, csb_pkg::CMD_ATTACH: begin
        if (fill_level >= csb_pkg::CAPACITY) begin
          outcome = csb_pkg::ST_FULL;
        end else begin
          // Without a cursor an insert goes to the front and an attach to the end.
          if (item.cmd == csb_pkg::CMD_INSERT) begin
            slot = cursor_live ? cursor_idx : 0;
          end else begin
            slot = cursor_live ? cursor_idx + 1 : fill_level;
          end
          for (i = fill_level; i > slot; i--) begin
            word_store[i] = word_store[i-1];
          end
          word_store[slot] = item.entry;
          fill_level++;
          cursor_idx  = slot;
          cursor_live = 1'b1;
        end
      end
      csb_pkg::CMD_REMOVE: begin
        if (!cursor_live) begin
          outcome = csb_pkg::ST_NOCUR;
        end else begin
          for (i = cursor_idx; i + 1 < fill_level; i++) begin
            word_store[i] = word_store[i+1];
          end
          fill_level--;
          // Removing the last entry leaves nothing to follow, so the cursor drops.
          if (cursor_idx >= fill_level) begin
            cursor_idx  = 0;
            cursor_live = 1'b0;
          end
        end
      end
      default: begin
      end
    endcase
    res.status        = outcome;
    res.count         = csb_pkg::CNT_W'(fill_level);
    res.has_current   = cursor_live;
    res.cursor_pos    = cursor_live ? csb_pkg::IDX_W'(cursor_idx) : '0;
    res.current_value = cursor_live ? word_store[cursor_idx] : '0;
    return res;
  endfunction

  // Data words lean toward the extremes now and then, otherwise they are uniform.
  function automatic logic [csb_pkg::DATA_W-1:0] random_word();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return csb_pkg::DATA_W'($urandom);
    endcase
  endfunction

  // Send one command transaction. The sender first idles for a random number of
  // cycles, then holds valid and the payload until the block takes them. When
  // there is no idle gap, valid simply stays high into the next transaction.
  task automatic send_command(input logic [2:0] op,
                              input logic [csb_pkg::DATA_W-1:0] word);
    int               gap;
    csb_pkg::csb_in_t item;
    gap        = steady_flow ? 0 : $urandom_range(0, MAX_WAIT);
    item.cmd   = op;
    item.entry = word;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted_results.push_back(apply_command(item));
  endtask

  // Stop sending and wait until the block has delivered every owed result.
  task automatic settle_outputs();
    in_valid <= 1'b0;
    @(posedge clk);
    while (predicted_results.size() != 0) @(posedge clk);
  endtask

  // Commands on an empty buffer: start finds nothing, advance and remove are
  // ignored without a cursor, and query and the spare codes change nothing.
  task automatic test_empty_buffer();
    send_command(csb_pkg::CMD_QUERY, '1);
    send_command(csb_pkg::CMD_START, '0);
    send_command(csb_pkg::CMD_ADVANCE, '1);
    send_command(csb_pkg::CMD_REMOVE, '1);
    send_command(CMD_SPARE_A, '1);
    send_command(CMD_SPARE_B, '0);
  endtask

  // Short directed sequence through insert, attach, advance and remove, with
  // the cursor at the front, in the middle, at the end and dropped.
  task automatic test_edit_commands();
    send_command(csb_pkg::CMD_INSERT, 32'h0000_0000);   // no cursor, goes to the front
    send_command(csb_pkg::CMD_ATTACH, 32'hFFFF_FFFF);   // after the cursor
    send_command(csb_pkg::CMD_INSERT, 32'hA5A5_A5A5);   // before the cursor
    send_command(csb_pkg::CMD_ADVANCE, '0);
    send_command(csb_pkg::CMD_ADVANCE, '0);             // past the last entry
    send_command(csb_pkg::CMD_ATTACH, 32'h5A5A_5A5A);   // no cursor, goes to the end
    send_command(csb_pkg::CMD_INSERT, 32'h8000_0000);
    send_command(csb_pkg::CMD_START, '1);
    send_command(csb_pkg::CMD_REMOVE, '1);              // first entry
    send_command(csb_pkg::CMD_ADVANCE, '0);
    send_command(csb_pkg::CMD_REMOVE, '0);              // middle entry
    send_command(csb_pkg::CMD_ADVANCE, '0);
    send_command(csb_pkg::CMD_REMOVE, '0);              // last entry, cursor drops
    send_command(csb_pkg::CMD_INSERT, 32'h0000_0001);
    send_command(csb_pkg::CMD_QUERY, '0);
  endtask

  // Empty the buffer, fill it to capacity with random words, check that a full
  // buffer refuses both insert and attach, then walk the cursor off the end.
  task automatic test_full_buffer();
    while (fill_level != 0) begin
      if (!cursor_live) begin
        send_command(csb_pkg::CMD_START, random_word());
      end
      send_command(csb_pkg::CMD_REMOVE, random_word());
    end
    while (fill_level < csb_pkg::CAPACITY) begin
      send_command(csb_pkg::CMD_ATTACH, random_word());
    end
    send_command(csb_pkg::CMD_INSERT, random_word());
    send_command(csb_pkg::CMD_ATTACH, random_word());
    send_command(csb_pkg::CMD_START, random_word());
    while (cursor_live) begin
      send_command(csb_pkg::CMD_ADVANCE, random_word());
    end
  endtask

  // Random commands in phases of a few dozen transactions. Each phase picks a
  // workload mix and sometimes runs without idle cycles on either side. Now
  // and then the sender also holds off until all results are back.
  task automatic test_random_mix(input int num_items);
    mix_t       mix;
    int         add_pct;
    int         del_pct;
    int         roll;
    logic [2:0] op;
    add_pct = 35;
    del_pct = 30;
    for (int n = 0; n < num_items; n++) begin
      if (n % PHASE_LEN == 0) begin
        mix         = mix_t'($urandom_range(0, 2));
        steady_flow = ($urandom_range(0, 3) == 0);
        case (mix)
          MIX_GROW: begin
            add_pct = 60;
            del_pct = 10;
          end
          MIX_SHRINK: begin
            add_pct = 15;
            del_pct = 50;
          end
          default: begin
            add_pct = 35;
            del_pct = 30;
          end
        endcase
      end
      roll = $urandom_range(0, 99);
      if (roll < add_pct) begin
        op = $urandom_range(0, 1) ? csb_pkg::CMD_INSERT : csb_pkg::CMD_ATTACH;
      end else if (roll < add_pct + del_pct) begin
        op = csb_pkg::CMD_REMOVE;
      end else if (roll < add_pct + del_pct + 12) begin
        op = csb_pkg::CMD_START;
      end else if (roll < 96) begin
        op = csb_pkg::CMD_ADVANCE;
      end else if (roll < 98) begin
        op = csb_pkg::CMD_QUERY;
      end else if (roll == 98) begin
        op = CMD_SPARE_A;
      end else begin
        op = CMD_SPARE_B;
      end
      send_command(op, random_word());
      if ($urandom_range(0, 99) == 0) begin
        settle_outputs();
      end
    end
    steady_flow = 1'b0;
  endtask

  // The receiver takes a result, then stalls for a random number of cycles
  // before it is ready again.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready  <= 1'b0;
      ready_hold = 0;
    end else begin
      if (out_valid && out_ready) begin
        ready_hold = steady_flow ? 0 : $urandom_range(0, MAX_WAIT);
      end else if (ready_hold > 0) begin
        ready_hold--;
      end
      out_ready <= (ready_hold == 0);
    end
  end

  // Every result transaction is checked field by field against the oldest
  // prediction. A result with nothing owed is a failure as well.
  always @(posedge clk) begin : result_check
    csb_pkg::csb_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (predicted_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT) begin
          $display("%0t: unexpected result status=%0d count=%0d has_current=%0b pos=%0d value=%h",
                   $realtime, out_data.status, out_data.count, out_data.has_current,
                   out_data.cursor_pos, out_data.current_value);
        end
      end else begin
        want = predicted_results.pop_front();
        if (out_data.status !== want.status || out_data.count !== want.count ||
            out_data.has_current !== want.has_current ||
            out_data.cursor_pos !== want.cursor_pos ||
            out_data.current_value !== want.current_value) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT) begin
            $display("%0t: result mismatch", $realtime);
            $display("  expected status=%0d count=%0d has_current=%0b pos=%0d value=%h",
                     want.status, want.count, want.has_current, want.cursor_pos,
                     want.current_value);
            $display("  actual   status=%0d count=%0d has_current=%0b pos=%0d value=%h",
                     out_data.status, out_data.count, out_data.has_current,
                     out_data.cursor_pos, out_data.current_value);
          end
        end
      end
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_buffer();
    test_edit_commands();
    // Hold off the sender once so that the block drains completely.
    settle_outputs();
    test_full_buffer();
    settle_outputs();
    test_random_mix(RANDOM_ITEMS);
    settle_outputs();
    // Extra idle cycles at the end catch any result the block sends without being asked.
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && predicted_results.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #400_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
